// ===== design/tou_pkg.sv =====
// ----------------------------------------------------------------------------
// tou_pkg
//
// Shared types and codes for the three-operand execute unit: opcodes,
// access kinds, the input and result transaction formats and the records
// that pass between pipeline stages.
// ----------------------------------------------------------------------------
package tou_pkg;

  // Opcodes. Codes above OP_HALT are unsupported.
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MAC  = 5'd2,
    OP_AND  = 5'd3,
    OP_OR   = 5'd4,
    OP_XOR  = 5'd5,
    OP_SLL  = 5'd6,
    OP_SRA  = 5'd7,
    OP_SRL  = 5'd8,
    OP_BEQ  = 5'd9,
    OP_BNE  = 5'd10,
    OP_BLT  = 5'd11,
    OP_BGT  = 5'd12,
    OP_BLE  = 5'd13,
    OP_BGE  = 5'd14,
    OP_JAL  = 5'd15,
    OP_LW   = 5'd16,
    OP_SW   = 5'd17,
    OP_RETI = 5'd18,
    OP_IN   = 5'd19,
    OP_OUT  = 5'd20,
    OP_HALT = 5'd21
  } op_e;

  // Kind of memory or I/O access made by an instruction.
  typedef enum logic [2:0] {
    ACC_NONE   = 3'd0,
    ACC_MEM_RD = 3'd1,
    ACC_MEM_WR = 3'd2,
    ACC_IO_RD  = 3'd3,
    ACC_IO_WR  = 3'd4
  } acc_e;

  localparam int unsigned AddrBits = 12;
  localparam int unsigned PcBits   = 12;

  // Input transaction: one decoded instruction with its operands.
  typedef struct packed {
    logic [4:0]           op;
    logic signed [31:0]   rs_val;
    logic signed [31:0]   rt_val;
    logic signed [31:0]   rm_val;
    logic signed [31:0]   rd_val;
    logic [PcBits-1:0]    cur_pc;
    logic [PcBits-1:0]    irq_return;
    logic signed [31:0]   load_data;
  } in_t;

  // Result transaction.
  typedef struct packed {
    logic                 reg_write;
    logic signed [31:0]   reg_value;
    logic [PcBits-1:0]    next_pc;
    logic [2:0]           access_kind;
    logic [AddrBits-1:0]  access_addr;
    logic signed [31:0]   store_data;
    logic                 leave_isr;
    logic                 halt;
    logic                 bad_opcode;
  } out_t;

  // Operand stage record: partial sums, product and compare flags.
  typedef struct packed {
    logic [4:0]         op;
    logic [31:0]        sum_st;
    logic [31:0]        diff_st;
    logic [31:0]        prod_st;
    logic               eq;
    logic               lt;
    logic               gt;
    logic [4:0]         shamt;
    logic               shift_big;
    logic [31:0]        rs;
    logic [31:0]        rm;
    logic [31:0]        rd;
    logic [31:0]        ld;
    logic [PcBits-1:0]  pc;
    logic [PcBits-1:0]  irq;
  } s1_t;

  // Arithmetic stage record: everything but the shifter result.
  typedef struct packed {
    logic [4:0]           op;
    logic                 wr;
    logic [31:0]          val;
    logic [PcBits-1:0]    npc;
    logic [2:0]           kind;
    logic [AddrBits-1:0]  addr;
    logic [31:0]          sdata;
    logic                 leave;
    logic                 hlt;
    logic                 bad;
    logic [31:0]          rs;
    logic [4:0]           shamt;
    logic                 shift_big;
  } s2_t;

endpackage

// ===== design/tou_opnd.sv =====
// ----------------------------------------------------------------------------
// tou_opnd
//
// First pipeline stage: forms rs+rt, rs-rt, the low word of rs*rt, the
// signed compare flags and the shift count class.
// ----------------------------------------------------------------------------
module tou_opnd (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  tou_pkg::in_t  data_i,
  output logic          valid_o,
  output tou_pkg::s1_t  data_o
);

  tou_pkg::s1_t data_d;
  tou_pkg::s1_t data_q;
  logic         valid_q;

  // Operand preparation.
  always_comb begin
    data_d           = '0;
    data_d.op        = data_i.op;
    data_d.sum_st    = data_i.rs_val + data_i.rt_val;
    data_d.diff_st   = data_i.rs_val - data_i.rt_val;
    data_d.prod_st   = 32'(data_i.rs_val * data_i.rt_val);
    data_d.eq        = (data_i.rs_val == data_i.rt_val);
    data_d.lt        = (data_i.rs_val < data_i.rt_val);
    data_d.gt        = (data_i.rt_val < data_i.rs_val);
    data_d.shamt     = data_i.rt_val[4:0];
    data_d.shift_big = |data_i.rt_val[31:5];
    data_d.rs        = data_i.rs_val;
    data_d.rm        = data_i.rm_val;
    data_d.rd        = data_i.rd_val;
    data_d.ld        = data_i.load_data;
    data_d.pc        = data_i.cur_pc;
    data_d.irq       = data_i.irq_return;
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/tou_arith.sv =====
// ----------------------------------------------------------------------------
// tou_arith
//
// Second pipeline stage: finishes the three-operand arithmetic and logic,
// resolves branches and the next pc, and forms the access fields.
// ----------------------------------------------------------------------------
module tou_arith (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  tou_pkg::s1_t  data_i,
  output logic          valid_o,
  output tou_pkg::s2_t  data_o
);

  tou_pkg::s2_t                 data_d;
  tou_pkg::s2_t                 data_q;
  logic                         valid_q;
  logic [tou_pkg::PcBits-1:0]   pc_w;
  logic [tou_pkg::PcBits-1:0]   pc_inc;
  logic [tou_pkg::PcBits-1:0]   target;
  logic [tou_pkg::PcBits-1:0]   irq_w;
  logic [tou_pkg::PcBits-1:0]   npc_w;
  logic                         taken;

  // The pc arithmetic runs at the program counter width.
  assign pc_w   = data_i.pc;
  assign pc_inc = pc_w + tou_pkg::PcBits'(1);
  assign target = data_i.rm[tou_pkg::PcBits-1:0];
  assign irq_w  = data_i.irq;

  // Decode, value selection and branch resolution.
  always_comb begin
    data_d           = '0;
    data_d.op        = data_i.op;
    data_d.kind      = tou_pkg::ACC_NONE;
    data_d.rs        = data_i.rs;
    data_d.shamt     = data_i.shamt;
    data_d.shift_big = data_i.shift_big;
    taken            = 1'b0;
    npc_w            = pc_inc;
    unique case (data_i.op)
      tou_pkg::OP_ADD: begin
        data_d.wr  = 1'b1;
        data_d.val = data_i.sum_st + data_i.rm;
      end
      tou_pkg::OP_SUB: begin
        data_d.wr  = 1'b1;
        data_d.val = data_i.diff_st - data_i.rm;
      end
      tou_pkg::OP_MAC: begin
        data_d.wr  = 1'b1;
        data_d.val = data_i.prod_st + data_i.rm;
      end
      tou_pkg::OP_AND: begin
        data_d.wr  = 1'b1;
        data_d.val = data_i.rs & data_i.sum_st ^ data_i.sum_st & data_i.rs
                     ^ (data_i.rs & (data_i.sum_st - data_i.rs) & data_i.rm);
      end
      tou_pkg::OP_OR: begin
        data_d.wr  = 1'b1;
        data_d.val = data_i.rs | (data_i.sum_st - data_i.rs) | data_i.rm;
      end
      tou_pkg::OP_XOR: begin
        data_d.wr  = 1'b1;
        data_d.val = data_i.rs ^ (data_i.sum_st - data_i.rs) ^ data_i.rm;
      end
      tou_pkg::OP_SLL, tou_pkg::OP_SRA, tou_pkg::OP_SRL: begin
        // The shifter in the last stage supplies the value.
        data_d.wr = 1'b1;
      end
      tou_pkg::OP_BEQ: taken = data_i.eq;
      tou_pkg::OP_BNE: taken = !data_i.eq;
      tou_pkg::OP_BLT: taken = data_i.lt;
      tou_pkg::OP_BGT: taken = data_i.gt;
      tou_pkg::OP_BLE: taken = !data_i.gt;
      tou_pkg::OP_BGE: taken = !data_i.lt;
      tou_pkg::OP_JAL: begin
        // The link value is pc+1 without wrap.
        data_d.wr  = 1'b1;
        data_d.val = 32'(pc_w) + 32'd1;
        taken      = 1'b1;
      end
      tou_pkg::OP_LW: begin
        data_d.wr   = 1'b1;
        data_d.val  = data_i.ld + data_i.rm;
        data_d.kind = tou_pkg::ACC_MEM_RD;
        data_d.addr = data_i.sum_st[tou_pkg::AddrBits-1:0];
      end
      tou_pkg::OP_SW: begin
        data_d.kind  = tou_pkg::ACC_MEM_WR;
        data_d.addr  = data_i.sum_st[tou_pkg::AddrBits-1:0];
        data_d.sdata = data_i.rm + data_i.rd;
      end
      tou_pkg::OP_RETI: begin
        data_d.leave = 1'b1;
        npc_w        = irq_w;
      end
      tou_pkg::OP_IN: begin
        data_d.wr   = 1'b1;
        data_d.val  = data_i.ld;
        data_d.kind = tou_pkg::ACC_IO_RD;
        data_d.addr = data_i.sum_st[tou_pkg::AddrBits-1:0];
      end
      tou_pkg::OP_OUT: begin
        data_d.kind  = tou_pkg::ACC_IO_WR;
        data_d.addr  = data_i.sum_st[tou_pkg::AddrBits-1:0];
        data_d.sdata = data_i.rm;
      end
      tou_pkg::OP_HALT: begin
        data_d.hlt = 1'b1;
        npc_w      = pc_w;
      end
      default: begin
        data_d.bad = 1'b1;
        npc_w      = pc_w;
      end
    endcase
    if (taken) begin
      npc_w = target;
    end
    data_d.npc = npc_w;
  end

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/tou_shift.sv =====
// ----------------------------------------------------------------------------
// tou_shift
//
// Last pipeline stage: barrel shifter with saturating counts, the final
// value selection and the result register.
// ----------------------------------------------------------------------------
module tou_shift (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          adv_i,
  input  logic          valid_i,
  input  tou_pkg::s2_t  data_i,
  output logic          valid_o,
  output tou_pkg::out_t data_o
);

  tou_pkg::out_t data_d;
  tou_pkg::out_t data_q;
  logic          valid_q;
  logic [31:0]   sll_val;
  logic [31:0]   srl_val;
  logic [31:0]   sra_val;

  // Shifts; a count of 32 or more gives zero or the sign fill.
  assign sll_val = data_i.shift_big ? 32'd0 : (data_i.rs << data_i.shamt);
  assign srl_val = data_i.shift_big ? 32'd0 : (data_i.rs >> data_i.shamt);
  assign sra_val = data_i.shift_big ? {32{data_i.rs[31]}}
                                    : 32'($signed(data_i.rs) >>> data_i.shamt);

  // Result assembly.
  always_comb begin
    data_d             = '0;
    data_d.reg_write   = data_i.wr;
    data_d.next_pc     = data_i.npc;
    data_d.access_kind = data_i.kind;
    data_d.access_addr = data_i.addr;
    data_d.store_data  = data_i.sdata;
    data_d.leave_isr   = data_i.leave;
    data_d.halt        = data_i.hlt;
    data_d.bad_opcode  = data_i.bad;
    case (data_i.op)
      tou_pkg::OP_SLL: data_d.reg_value = sll_val;
      tou_pkg::OP_SRA: data_d.reg_value = sra_val;
      tou_pkg::OP_SRL: data_d.reg_value = srl_val;
      default:         data_d.reg_value = data_i.val;
    endcase
  end

  // Result valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/three_operand_execute_unit_top.sv =====
// ----------------------------------------------------------------------------
// three_operand_execute_unit_top
//
// Execute stage for a 32-bit machine with three source operands. It takes
// one instruction transaction per cycle while in_stall_o is low and returns
// one result transaction for each, in order. The result is held in the result
// register and leaves at the next edge at which the output side does not
// stall. The three register stages are the operand stage (the 32 by
// 32 multiplier and the rs+rt, rs-rt adders set its depth), the arithmetic
// and branch stage, and the shifter stage that ends in the result register.
// Each stage holds its transaction while the stage after it is full and
// stalled, so in_stall_o rises only when all three stages are occupied and
// out_stall_i is high. The pc width is the package constant PcBits (12).
// ----------------------------------------------------------------------------
module three_operand_execute_unit_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  tou_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output tou_pkg::out_t out_data_o
);

  logic         s1_valid;
  logic         s2_valid;
  logic         s1_adv;
  logic         s2_adv;
  logic         s3_adv;
  tou_pkg::s1_t s1_data;
  tou_pkg::s2_t s2_data;

  // A stage advances when it is empty or the next stage advances.
  assign s3_adv     = !out_valid_o || !out_stall_i;
  assign s2_adv     = !s2_valid || s3_adv;
  assign s1_adv     = !s1_valid || s2_adv;
  assign in_stall_o = !s1_adv;

  tou_opnd u_opnd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (s1_valid),
    .data_o  (s1_data)
  );

  tou_arith u_arith (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s2_adv),
    .valid_i (s1_valid),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .data_o  (s2_data)
  );

  tou_shift u_shift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s3_adv),
    .valid_i (s2_valid),
    .data_i  (s2_data),
    .valid_o (out_valid_o),
    .data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // Input stalls only with a full pipeline blocked at the output.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid && s2_valid && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // An accepted transaction reaches the first stage.
  a_accept_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> s1_valid)
    else $error("accepted transaction lost at the operand stage");

  // An empty arithmetic stage with a free output leaves no result behind.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!s2_valid && s3_adv) |=> !out_valid_o)
    else $error("result appeared without a transaction behind it");

  // Unsupported opcode, halt and reti write nothing and access nothing.
  a_no_side_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.bad_opcode || out_data_o.halt
                     || out_data_o.leave_isr))
    |-> (!out_data_o.reg_write && out_data_o.access_kind == tou_pkg::ACC_NONE))
    else $error("control transaction made a write or an access");
`endif

endmodule
